// File: design/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared constants for the positional list engine
// Default sizes, field widths, command codes and status codes.
// ----------------------------------------------------------------------------
package ple_pkg;

    // default sizes
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // request and result field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // packed stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD_FRONT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_REAR      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INSERT_BEFORE = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// File: design/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list with positional insert and delete
// Keeps up to CAPACITY signed values in a single-port-style memory and
// moves elements one slot at a time under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on s_tvalid/s_tready/s_tdata: command, 1-based position
//   and value. Each request gives exactly one result on m_tvalid/m_tready/
//   m_tdata: removed value, status and element count after the request.
//   A request that fails or carries an unused command goes through the check
//   state straight to the result hand-off; an insert at slot s first shifts
//   every element from slot s onward one slot toward the rear, and a removal
//   at slot s shifts every element behind it one slot toward the front. Each
//   moved element costs one registered memory read and one write.
//   s_tready is high only while the sequencer waits for a request, so a new
//   request is taken only after the previous result has left the sequencer.
//   A result waits in the output register while the receiver stalls; the
//   next request is taken and worked on meanwhile, and its result holds in
//   the sequencer until the output register is free.
//   Reset empties the list at once (no clearing pass); list contents are
//   only read below the current length.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ple_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request: command [2:0], position [7:3], value [39:8]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ple_pkg::IN_TDATA_W-1:0]  s_tdata,
    // result: removed_value [31:0], status [33:32], count [38:34], zero [39]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ple_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam int EXT_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD0,
        S_REM_GET,
        S_REM_RD,
        S_REM_WR,
        S_PUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       slot_reg, slot_next;
    logic [LEN_W-1:0]       cursor_reg, cursor_next;
    logic [DATA_W-1:0]      removed_reg, removed_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      out_removed_reg, out_removed_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;

    // list storage
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   wr_en;

    // shared cursor arithmetic
    logic [LEN_W-1:0]       cur_dec;
    logic [LEN_W:0]         cur_inc;
    logic [LEN_W:0]         cur_inc2;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       len_ext;
    logic [CMP_W-1:0]       pos_dec;
    logic                   is_empty;
    logic                   is_full;
    logic signed [VALUE_WIDTH-1:0] rd_signed;
    logic signed [EXT_W-1:0]       rd_ext;

    // length minus one
    function automatic logic [LEN_W-1:0] cur_len_dec();
        return len_reg - LEN_W'(1);
    endfunction

    assign cur_dec  = cursor_reg - LEN_W'(1);
    assign cur_inc  = {1'b0, cursor_reg} + (LEN_W + 1)'(1);
    assign cur_inc2 = {1'b0, cursor_reg} + (LEN_W + 1)'(2);
    assign pos_ext  = CMP_W'(pos_reg);
    assign len_ext  = CMP_W'(len_reg);
    assign pos_dec  = pos_ext - CMP_W'(1);
    assign is_empty = (len_reg == '0);
    assign is_full  = (len_ext >= CMP_W'(CAPACITY));
    assign rd_signed = rd_data_reg;
    assign rd_ext    = EXT_W'(rd_signed);

    // stream ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_status_reg, out_removed_reg};

    // memory address and write control
    always_comb
    begin
        rd_addr = '0;
        wr_addr = cursor_reg[IDX_W-1:0];
        wr_data = rd_data_reg;
        wr_en   = 1'b0;
        unique case (state_reg)
            S_INS_RD:  rd_addr = cur_dec[IDX_W-1:0];
            S_INS_WR:  wr_en = 1'b1;
            S_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_reg[IDX_W-1:0];
                wr_data = val_reg;
            end
            S_REM_RD0: rd_addr = slot_reg[IDX_W-1:0];
            S_REM_RD:  rd_addr = cur_inc[IDX_W-1:0];
            S_REM_WR:  wr_en = 1'b1;
            default:   ;
        endcase
    end

    // list memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        len_next         = len_reg;
        slot_next        = slot_reg;
        cursor_next      = cursor_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg;
        out_removed_next = out_removed_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;

        // output register drains independently
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[CMD_W-1:0];
                    pos_next   = s_tdata[CMD_W +: POS_W];
                    val_next   = VALUE_WIDTH'($unsigned(s_tdata[CMD_W+POS_W +: DATA_W]));
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                removed_next = '0;
                status_next  = ST_OK;
                state_next   = S_PUSH;
                unique case (cmd_reg)
                    CMD_ADD_FRONT, CMD_ADD_REAR:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            slot_next   = (cmd_reg == CMD_ADD_FRONT) ? '0 : len_reg;
                            cursor_next = len_reg;
                            state_next  = (cmd_reg == CMD_ADD_FRONT && !is_empty)
                                          ? S_INS_RD : S_INS_PUT;
                        end
                    end
                    CMD_REMOVE_FRONT, CMD_REMOVE_REAR:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            slot_next  = (cmd_reg == CMD_REMOVE_FRONT) ? '0 : cur_len_dec();
                            state_next = S_REM_RD0;
                        end
                    end
                    CMD_REMOVE_AT:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else if (pos_reg == '0 || pos_ext > len_ext)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            slot_next  = pos_dec[LEN_W-1:0];
                            state_next = S_REM_RD0;
                        end
                    end
                    CMD_INSERT_BEFORE:
                    begin
                        if (pos_reg == '0 || pos_dec > len_ext)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            slot_next   = pos_dec[LEN_W-1:0];
                            cursor_next = len_reg;
                            state_next  = (len_ext > pos_dec) ? S_INS_RD : S_INS_PUT;
                        end
                    end
                    default: ;
                endcase
            end

            // shift toward the rear, one element per read/write pair
            S_INS_RD:  state_next = S_INS_WR;
            S_INS_WR:
            begin
                cursor_next = cur_dec;
                state_next  = (cur_dec > slot_reg) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT:
            begin
                len_next   = len_reg + LEN_W'(1);
                state_next = S_PUSH;
            end

            // take the element, then shift toward the front
            S_REM_RD0:
            begin
                cursor_next = slot_reg;
                state_next  = S_REM_GET;
            end
            S_REM_GET:
            begin
                removed_next = rd_ext[DATA_W-1:0];
                if (cur_inc < {1'b0, len_reg})
                begin
                    state_next = S_REM_RD;
                end
                else
                begin
                    len_next   = cur_len_dec();
                    state_next = S_PUSH;
                end
            end
            S_REM_RD:  state_next = S_REM_WR;
            S_REM_WR:
            begin
                cursor_next = cur_inc[LEN_W-1:0];
                if (cur_inc2 < {1'b0, len_reg})
                begin
                    state_next = S_REM_RD;
                end
                else
                begin
                    len_next   = cur_len_dec();
                    state_next = S_PUSH;
                end
            end

            // hand the result to the output register once it is free
            S_PUSH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_removed_next = removed_reg;
                    out_status_next  = status_reg;
                    out_count_next   = COUNT_W'(len_reg);
                    state_next       = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_removed_reg <= '0;
            out_status_reg  <= ST_OK;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            out_valid_reg   <= out_valid_next;
            out_removed_reg <= out_removed_next;
            out_status_reg  <= out_status_next;
            out_count_reg   <= out_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        slot_reg        <= slot_next;
        cursor_reg      <= cursor_next;
        removed_reg     <= removed_next;
        status_reg      <= status_next;
    end

endmodule
